[design/cscan_pkg.sv]
package cscan_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [23:0] MOVE_MAX = 24'hFF_FFFF;

   localparam logic [7:0] END_CYLINDER_RST = 8'd31;
   localparam logic [7:0] START_HEAD_RST   = 8'd15;

   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_SERVE = 1'b1;

   localparam logic REG_END_CYLINDER = 1'b0;
   localparam logic REG_START_HEAD   = 1'b1;

   typedef struct packed {
      logic       command;
      logic [7:0] cylinder;
   } req_type;

   typedef struct packed {
      logic        served_valid;
      logic [7:0]  served_cylinder;
      logic [23:0] total_movement;
      logic        dropped;
      logic [4:0]  pending;
   } rsp_type;

   // scan token walked down the cell row, one cell per cycle
   typedef struct packed {
      logic             active;
      logic             command;
      logic [7:0]       cylinder;
      logic [7:0]       head;
      logic             placed;
      logic             above_found;
      logic [7:0]       above_cyl;
      logic [IDX_W-1:0] above_idx;
      logic             any_found;
      logic [7:0]       any_cyl;
      logic [IDX_W-1:0] any_idx;
   } token_type;

   typedef struct packed {
      logic             strobe;
      logic [IDX_W-1:0] idx;
   } clear_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

[design/cscan_cell.sv]
module cscan_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [cscan_pkg::IDX_W-1:0] cell_idx,
   input  cscan_pkg::token_type      tok_in,
   input  cscan_pkg::clear_type      clr,
   output cscan_pkg::token_type      tok_out
);
   import cscan_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] cyl_ff, cyl_in;
   token_type  tok_ff, tok_in_next;

   always_comb begin
      valid_in    = valid_ff;
      cyl_in      = cyl_ff;
      tok_in_next = tok_in;
      if (tok_in.active && tok_in.command == CMD_ADD) begin
         // first free slot claims the request
         if (!tok_in.placed && !valid_ff) begin
            valid_in           = 1'b1;
            cyl_in             = tok_in.cylinder;
            tok_in_next.placed = 1'b1;
         end
      end else if (tok_in.active && tok_in.command == CMD_SERVE && valid_ff) begin
         // strict less keeps the lower slot on ties
         if (cyl_ff > tok_in.head &&
             (!tok_in.above_found || cyl_ff < tok_in.above_cyl)) begin
            tok_in_next.above_found = 1'b1;
            tok_in_next.above_cyl   = cyl_ff;
            tok_in_next.above_idx   = cell_idx;
         end
         if (!tok_in.any_found || cyl_ff < tok_in.any_cyl) begin
            tok_in_next.any_found = 1'b1;
            tok_in_next.any_cyl   = cyl_ff;
            tok_in_next.any_idx   = cell_idx;
         end
      end
      if (clr.strobe && clr.idx == cell_idx) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in_next;
      end
   end

   always_ff @(posedge clock) begin
      cyl_ff <= cyl_in;
   end

   assign tok_out = tok_ff;

endmodule

[design/cscan_disk_request_scheduler_top.sv]
// req_stall is low only in ST_IDLE, so a new request waits until the last result is loaded.
// The token walks the cell row one slot per cycle, then the scan is latched and the finish
// state settles head, total and count.
// A finished result may wait in the output register while the next request is taken.
// Reset (synchronous, active high): table empty, head 15, total 0, end_cylinder 31,
// start_head 15.
module cscan_disk_request_scheduler_top (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  cscan_pkg::req_type   req_data,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output cscan_pkg::rsp_type   rsp_data,
   // APB-style register port
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   import cscan_pkg::*;

   // ---------------------------------------------------------------
   // Configuration registers. Register index is paddr[2].
   // start_head is readable but never loads the head; reset loads START_HEAD_RST.
   // ---------------------------------------------------------------
   logic [7:0] end_cyl_ff, end_cyl_in;
   logic [7:0] start_head_ff, start_head_in;
   logic       cfg_write;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_comb begin
      end_cyl_in    = end_cyl_ff;
      start_head_in = start_head_ff;
      if (cfg_write) begin
         case (paddr[2])
            REG_END_CYLINDER: end_cyl_in    = pwdata[7:0];
            REG_START_HEAD:   start_head_in = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_END_CYLINDER: prdata = {24'd0, end_cyl_ff};
         REG_START_HEAD:   prdata = {24'd0, start_head_ff};
         default:          prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------
   // Controller state
   // ---------------------------------------------------------------
   state_type        state_ff, state_in;
   logic [7:0]       head_ff, head_in;
   logic [23:0]      total_ff, total_in;
   logic [CNT_W-1:0] count_ff, count_in;
   token_type        result_ff, result_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic      req_accept;
   logic      scan_done;
   logic      rsp_free;
   logic      load_rsp;
   logic      latch_result;
   clear_type clr;

   // token chain: link 0 is the injected token, link k+1 leaves cell k
   token_type tok_link [QUEUE_DEPTH+1];

   assign req_accept = req_valid && !req_stall;
   assign scan_done  = tok_link[QUEUE_DEPTH].active;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      tok_link[0]          = '0;
      tok_link[0].active   = req_accept;
      tok_link[0].command  = req_data.command;
      tok_link[0].cylinder = req_data.cylinder;
      tok_link[0].head     = head_ff;
   end

   // ---------------------------------------------------------------
   // Cell row: each cell holds one table slot and forwards the token
   // ---------------------------------------------------------------
   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      cscan_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (IDX_W'(g)),
         .tok_in   (tok_link[g]),
         .clr      (clr),
         .tok_out  (tok_link[g+1])
      );
   end

   // ---------------------------------------------------------------
   // FSM: next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_accept) state_in = ST_SCAN;
         ST_SCAN:   if (scan_done) state_in = ST_FINISH;
         ST_FINISH: if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // FSM: outputs
   always_comb begin
      req_stall    = 1'b1;
      latch_result = 1'b0;
      load_rsp     = 1'b0;
      case (state_ff)
         ST_IDLE:   req_stall    = 1'b0;
         ST_SCAN:   latch_result = scan_done;
         ST_FINISH: load_rsp     = rsp_free;
         default:   ;
      endcase
   end

   // ---------------------------------------------------------------
   // Finish: pick the served slot and settle head, total and count.
   // The wrap sums end sweep and climb from zero before saturating;
   // two saturating adds of non-negative steps give the same total.
   // ---------------------------------------------------------------
   logic [8:0]  sweep;
   logic [9:0]  amount;
   logic [24:0] sum;
   logic [23:0] sat_total;
   logic        pick_valid;
   logic [7:0]  pick_cyl;
   logic [IDX_W-1:0] pick_idx;

   always_comb begin
      sweep = (end_cyl_ff > result_ff.head) ? {1'b0, end_cyl_ff - result_ff.head}
                                            : {1'b0, result_ff.head - end_cyl_ff};
      if (result_ff.above_found) begin
         pick_valid = 1'b1;
         pick_cyl   = result_ff.above_cyl;
         pick_idx   = result_ff.above_idx;
         amount     = {2'd0, result_ff.above_cyl - result_ff.head};
      end else begin
         pick_valid = result_ff.any_found;
         pick_cyl   = result_ff.any_cyl;
         pick_idx   = result_ff.any_idx;
         amount     = {1'b0, sweep} + {2'd0, result_ff.any_cyl};
      end
      sum       = {1'b0, total_ff} + {15'd0, amount};
      sat_total = sum[24] ? MOVE_MAX : sum[23:0];
   end

   always_comb begin
      head_in      = head_ff;
      total_in     = total_ff;
      count_in     = count_ff;
      result_in    = latch_result ? tok_link[QUEUE_DEPTH] : result_ff;
      clr          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         if (result_ff.command == CMD_ADD) begin
            if (result_ff.placed) begin
               count_in = count_ff + CNT_W'(1);
            end
            rsp_data_in.dropped = !result_ff.placed;
         end else if (pick_valid) begin
            clr.strobe = 1'b1;
            clr.idx    = pick_idx;
            head_in    = pick_cyl;
            total_in   = sat_total;
            if (count_ff != '0) begin
               count_in = count_ff - CNT_W'(1);
            end
            rsp_data_in.served_valid    = 1'b1;
            rsp_data_in.served_cylinder = pick_cyl;
         end
         rsp_data_in.total_movement = total_in;
         rsp_data_in.pending        = 5'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         end_cyl_ff    <= END_CYLINDER_RST;
         start_head_ff <= START_HEAD_RST;
         head_ff       <= START_HEAD_RST;
         total_ff      <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         end_cyl_ff    <= end_cyl_in;
         start_head_ff <= start_head_in;
         head_ff       <= head_in;
         total_ff      <= total_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[verif/tb_cscan_disk_request_scheduler_top.sv]
module tb_cscan_disk_request_scheduler_top;
   import cscan_pkg::*;

   // Quiet cycles allowed with no request or result moving. The limit is well
   // above a full scan, the sender's longest idle gap and a stalled result.
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LIMIT   = 10;
   // after the last result: one full scan plus margin to catch stray results
   localparam int DRAIN_CYCLES   = QUEUE_DEPTH + 2 + 16;

   // ---------------------------------------------------------------------
   // DUT ports; every input is known from time zero
   // ---------------------------------------------------------------------
   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        psel      = 1'b0;
   logic        penable   = 1'b0;
   logic        pwrite    = 1'b0;
   logic [2:0]  paddr     = '0;
   logic [31:0] pwdata    = '0;
   logic [31:0] prdata;
   logic        pready;

   cscan_disk_request_scheduler_top dut (.*);

   // ---------------------------------------------------------------------
   // Scheduler shadow: request table, head, travel total, pending count and
   // the two registers; the request state is updated at the edge each request
   // is accepted, the registers at each write.
   logic [7:0]  slot_cylinder [QUEUE_DEPTH];
   logic        slot_busy     [QUEUE_DEPTH];
   logic [7:0]  head_cylinder;
   logic [23:0] head_travel;
   int          waiting_count;
   logic [7:0]  end_cylinder_reg;
   logic [7:0]  start_head_reg;

   // results owed by the DUT, oldest first
   rsp_type     schedule_results [$];

   // idle mix for the current phase, in percent
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;

   // bookkeeping
   int mismatches      = 0;
   int results_checked = 0;
   int adds_sent       = 0;
   int serves_sent     = 0;
   int drops_seen      = 0;
   int wraps_seen      = 0;
   int ceiling_hits    = 0;
   int quiet_cycles    = 0;

   // ---------------------------------------------------------------------
   // Clock
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------
   // head travel never wraps: it sticks at MOVE_MAX
   function automatic logic [23:0] travel_add(input logic [23:0] base,
                                              input logic [23:0] amount);
      logic [24:0] sum;
      sum = {1'b0, base} + {1'b0, amount};
      return sum[24] ? MOVE_MAX : sum[23:0];
   endfunction

   // Apply one accepted request to the shadow and return the result it owes.
   // Serve: nearest busy cylinder strictly above the head; failing that the
   // head sweeps to end_cylinder (either direction), jumps to zero uncounted
   // and climbs to the lowest busy cylinder. Ties go to the lowest slot.
   function automatic rsp_type schedule_request(input req_type item);
      rsp_type    outcome;
      int         free_slot;
      int         pick;
      logic [7:0] best;
      outcome   = '0;
      free_slot = -1;
      pick      = -1;
      best      = '0;
      if (item.command == CMD_ADD) begin
         adds_sent++;
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (!slot_busy[i] && free_slot < 0) free_slot = i;
         end
         if (free_slot < 0) begin
            outcome.dropped = 1'b1;
            drops_seen++;
         end else begin
            slot_cylinder[free_slot] = item.cylinder;
            slot_busy[free_slot]     = 1'b1;
            waiting_count++;
         end
      end else begin
         serves_sent++;
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (slot_busy[i] && slot_cylinder[i] > head_cylinder &&
                (pick < 0 || slot_cylinder[i] < best)) begin
               pick = i;
               best = slot_cylinder[i];
            end
         end
         if (pick >= 0) begin
            head_travel = travel_add(head_travel, best - head_cylinder);
         end else begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
               if (slot_busy[i] && (pick < 0 || slot_cylinder[i] < best)) begin
                  pick = i;
                  best = slot_cylinder[i];
               end
            end
            if (pick >= 0) begin
               head_travel = travel_add(head_travel,
                  (end_cylinder_reg > head_cylinder) ? end_cylinder_reg - head_cylinder
                                                     : head_cylinder - end_cylinder_reg);
               head_travel = travel_add(head_travel, best);
               wraps_seen++;
            end
         end
         if (pick >= 0) begin
            slot_busy[pick]         = 1'b0;
            waiting_count--;
            head_cylinder           = best;
            outcome.served_valid    = 1'b1;
            outcome.served_cylinder = best;
         end
      end
      outcome.total_movement = head_travel;
      outcome.pending        = 5'(waiting_count);
      return outcome;
   endfunction

   task automatic note_failure(input string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("%s", msg);
   endtask

   // ---------------------------------------------------------------------
   // Request side: optional idle gap of random length so that the next
   // request lands on any cycle of the scan, then hold until taken.
   // ---------------------------------------------------------------------
   task automatic send_request(input logic command, input logic [7:0] cylinder);
      req_type item;
      item.command  = command;
      item.cylinder = cylinder;
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(40, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      schedule_results.push_back(schedule_request(item));
   endtask

   // stop sending and wait for every owed result
   task automatic settle();
      req_valid <= 1'b0;
      while (schedule_results.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Register port: setup cycle, then access until pready
   // ---------------------------------------------------------------------
   task automatic write_register(input logic reg_idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (reg_idx == REG_END_CYLINDER) end_cylinder_reg = value[7:0];
      else start_head_reg = value[7:0];
   endtask

   task automatic check_register(input logic reg_idx);
      logic [7:0] want;
      want = (reg_idx == REG_END_CYLINDER) ? end_cylinder_reg : start_head_reg;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {reg_idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      // prdata as seen in the access phase
      if (prdata[7:0] !== want)
         note_failure($sformatf("register %0d readback: expected %0d, got %0d",
                                reg_idx, want, prdata[7:0]));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Result side: check at each accepted result, then pick the next stall
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (schedule_results.size() == 0) begin
            note_failure($sformatf("unexpected result: served=%0b/%0d travel=%0d",
                                   rsp_data.served_valid, rsp_data.served_cylinder,
                                   rsp_data.total_movement));
         end else begin
            want = schedule_results.pop_front();
            results_checked++;
            if (want.total_movement == MOVE_MAX) ceiling_hits++;
            if (rsp_data.served_valid    !== want.served_valid    ||
                rsp_data.served_cylinder !== want.served_cylinder ||
                rsp_data.total_movement  !== want.total_movement  ||
                rsp_data.dropped         !== want.dropped         ||
                rsp_data.pending         !== want.pending)
               note_failure($sformatf({"result %0d: expected served=%0b/%0d travel=%0d ",
                  "dropped=%0b pending=%0d, got served=%0b/%0d travel=%0d dropped=%0b ",
                  "pending=%0d"}, results_checked,
                  want.served_valid, want.served_cylinder, want.total_movement,
                  want.dropped, want.pending,
                  rsp_data.served_valid, rsp_data.served_cylinder,
                  rsp_data.total_movement, rsp_data.dropped, rsp_data.pending));
         end
      end
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // ---------------------------------------------------------------------
   // Watchdog: too long without any request or result moving
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no traffic for %0d cycles, %0d results outstanding",
                  quiet_cycles, schedule_results.size());
         $display("** cscan_disk_request_scheduler_top: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // reset values, then writes with junk in the upper bits; start_head never
   // loads the head, so the shadow head stays put
   task automatic test_register_access();
      check_register(REG_END_CYLINDER);
      check_register(REG_START_HEAD);
      write_register(REG_START_HEAD, 32'hA5A5_A5C8);
      write_register(REG_END_CYLINDER, 32'h5A5A_5A1F);
      check_register(REG_START_HEAD);
      check_register(REG_END_CYLINDER);
   endtask

   // head 15, end 31 out of reset
   task automatic test_directed_cases();
      send_request(CMD_SERVE, 8'hFF);    // empty table: nothing served
      send_request(CMD_ADD, 8'd15);      // equal to head: only via wrap
      send_request(CMD_SERVE, 8'h00);
      send_request(CMD_ADD, 8'd0);
      send_request(CMD_ADD, 8'd255);
      send_request(CMD_ADD, 8'd20);
      send_request(CMD_SERVE, 8'h00);    // 20, nearest above
      send_request(CMD_SERVE, 8'h00);    // 255
      send_request(CMD_SERVE, 8'h00);    // wrap with head past end_cylinder
   endtask

   // fill all slots (duplicates included), overflow once, serve a couple
   task automatic test_full_table();
      logic [7:0] fill [16] = '{8'hAA, 8'h55, 8'hAA, 8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h01,
                                8'h80, 8'hFE, 8'h7F, 8'hAA, 8'h64, 8'hC8, 8'h32, 8'h55};
      for (int i = 0; i < QUEUE_DEPTH; i++) send_request(CMD_ADD, fill[i % 16]);
      send_request(CMD_ADD, 8'hFF);      // table full: dropped
      send_request(CMD_SERVE, 8'h00);
      send_request(CMD_SERVE, 8'h00);
   endtask

   function automatic logic [7:0] pick_cylinder();
      case ($urandom_range(7))
         0: return head_cylinder;
         1: return $urandom_range(1) ? 8'hFF : 8'h00;
         2: return end_cylinder_reg;
         3: return head_cylinder + 8'd1;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic run_traffic(input int n_items, input int add_pct);
      repeat (n_items) begin
         if ($urandom_range(99) < add_pct) send_request(CMD_ADD, pick_cylinder());
         else send_request(CMD_SERVE, 8'($urandom_range(255)));
      end
   endtask

   // four idle mixes; end_cylinder and start_head move between them,
   // extremes first; bursts lean toward filling or draining the table
   task automatic test_random_traffic();
      int         idle_mix [4][2] = '{'{0, 0}, '{63, 0}, '{0, 63}, '{21, 21}};
      logic [7:0] end_value;
      logic [7:0] start_value;
      for (int phase = 0; phase < 4; phase++) begin
         settle();
         end_value   = (phase == 0) ? 8'h00 : (phase == 1) ? 8'hFF : 8'($urandom_range(255));
         start_value = (phase == 0) ? 8'hFF : (phase == 1) ? 8'h00 : 8'($urandom_range(255));
         write_register(REG_END_CYLINDER, {24'($urandom), end_value});
         write_register(REG_START_HEAD, {24'($urandom), start_value});
         check_register(REG_END_CYLINDER);
         check_register(REG_START_HEAD);
         sender_idle_pct    = idle_mix[phase][0];
         receiver_stall_pct = idle_mix[phase][1];
         repeat (4) run_traffic(38, $urandom_range(80, 25));
      end
   endtask

   // Longest wraps: with end_cylinder 0, once the head is at 255 each
   // add-255/serve pair sweeps 255 back to the end and climbs 255 again.
   task automatic test_long_wraps();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      while (waiting_count > 0) send_request(CMD_SERVE, 8'h00);
      settle();
      write_register(REG_END_CYLINDER, 32'h0);
      repeat (5) begin
         send_request(CMD_ADD, 8'hFF);
         send_request(CMD_SERVE, 8'h00);
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      foreach (slot_busy[i]) begin
         slot_busy[i]     = 1'b0;
         slot_cylinder[i] = '0;
      end
      head_cylinder    = START_HEAD_RST;
      head_travel      = '0;
      waiting_count    = 0;
      end_cylinder_reg = END_CYLINDER_RST;
      start_head_reg   = START_HEAD_RST;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_access();
      test_directed_cases();
      test_full_table();
      test_random_traffic();
      test_long_wraps();

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d results checked: %0d adds (%0d dropped), %0d serves (%0d wrapped)",
               results_checked, adds_sent, drops_seen, serves_sent, wraps_seen);
      $display("travel total at its ceiling in %0d results; %0d mismatches",
               ceiling_hits, mismatches);
      if (mismatches == 0) begin
         $display("** cscan_disk_request_scheduler_top: PASSED **");
      end else begin
         $display("** cscan_disk_request_scheduler_top: FAILED **");
      end
      $finish;
   end

endmodule
